FILE: src/fenwick_max_subsequence_lengths_unit_assert.svh
// Assertion macros shared by the RTL, clocked on i_clk, off during reset.
`ifndef FENWICK_MAX_SUBSEQUENCE_LENGTHS_UNIT_ASSERT_SVH
`define FENWICK_MAX_SUBSEQUENCE_LENGTHS_UNIT_ASSERT_SVH

// Same-cycle implication
`define FMSL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FMSL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/fmsl_pkg.sv
`timescale 1ns / 1ps

package fmsl_pkg;

    // Field widths of the request and result channels
    localparam int HEIGHT_FIELD_BITS = 16;
    localparam int LEN_FIELD_BITS    = 16;

    // Tree geometry and length width
    localparam int HEIGHT_BITS = 16;
    localparam int LENGTH_BITS = 16;
    localparam int TREE_SIZE   = 1 << HEIGHT_BITS;
    localparam int POS_BITS    = HEIGHT_BITS + 2;

    // Tree lanes
    localparam int NUM_TREES = 2;
    localparam int TREE_NI   = 0;   // non-increasing, reversed index
    localparam int TREE_IN   = 1;   // strictly increasing, direct index

    typedef logic [HEIGHT_BITS-1:0] t_addr;
    typedef logic [POS_BITS-1:0]    t_pos;
    typedef logic [LENGTH_BITS-1:0] t_len;

    localparam t_pos TREE_POS = t_pos'(t_pos'(1) << HEIGHT_BITS);
    localparam t_len LEN_MAX  = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_UPINIT,
        S_UPDATE,
        S_DONE
    } t_state;

    // Lowest set bit of a tree position
    function automatic t_pos lowbit(input t_pos p);
        return p & (~p + t_pos'(1));
    endfunction

    // Extend a length by one item, saturating
    function automatic t_len bump(input t_len q);
        return (q == LEN_MAX) ? q : q + t_len'(1);
    endfunction

    function automatic t_len max_len(input t_len a, input t_len b);
        return (a > b) ? a : b;
    endfunction

    // Clamp a length into the result field
    function automatic logic [LEN_FIELD_BITS-1:0] to_field(input t_len v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'h0_FFFF) ? '1 : w[LEN_FIELD_BITS-1:0];
    endfunction

endpackage

FILE: src/fmsl_if.sv
`timescale 1ns / 1ps

// Request channel: one height per request
interface fmsl_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [fmsl_pkg::HEIGHT_FIELD_BITS-1:0] height;
    logic                                   last_item;

    modport source (output valid, output height, output last_item, input ready);
    modport sink   (input valid, input height, input last_item, output ready);
endinterface

// Result channel: both running lengths per request
interface fmsl_out_if;
    logic                                valid;
    logic                                ready;
    logic [fmsl_pkg::LEN_FIELD_BITS-1:0] nonincreasing_length;
    logic [fmsl_pkg::LEN_FIELD_BITS-1:0] increasing_length;
    logic                                is_final;

    modport source (output valid, output nonincreasing_length, output increasing_length,
                    output is_final, input ready);
    modport sink   (input valid, input nonincreasing_length, input increasing_length,
                    input is_final, output ready);
endinterface

FILE: src/fenwick_max_subsequence_lengths_unit.sv
`timescale 1ns / 1ps
// Channel | Port  | Direction | Payload
// --------+-------+-----------+---------------------------------------------------
// request | i_in  | sink      | height, last_item
// result  | o_out | source    | nonincreasing_length, increasing_length, is_final
//
// Each request runs a query walk and then an update walk: the tree walks
// read one node per cycle on each tree's single read port.
// Both trees walk in parallel; a result waits in an output register while the
// next request is taken. After reset and after each last_item request, a clearing
// pass writes zero to all 2^HEIGHT_BITS tree entries, one per cycle, with no
// request taken. Result stalls delay only the handoff into the output register.
`include "fenwick_max_subsequence_lengths_unit_assert.svh"

module fenwick_max_subsequence_lengths_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fmsl_in_if.sink         i_in,
    fmsl_out_if.source      o_out
);

    fmsl_pkg::t_state r_state, n_state;
    fmsl_pkg::t_addr  r_clr_cnt;
    logic             r_last;

    // Per-tree walk state
    fmsl_pkg::t_pos   r_qpos    [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_pos   r_upos    [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_len   r_acc     [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_len   r_val     [fmsl_pkg::NUM_TREES];
    logic             r_rd_vld  [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_addr  r_wr_addr [fmsl_pkg::NUM_TREES];

    fmsl_pkg::t_len   r_best_ni;
    fmsl_pkg::t_len   r_best_in;

    // Output register
    logic                                r_out_vld;
    logic [fmsl_pkg::LEN_FIELD_BITS-1:0] r_out_ni;
    logic [fmsl_pkg::LEN_FIELD_BITS-1:0] r_out_in;
    logic                                r_out_final;

    // Memory port controls
    logic             s_rd_en   [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_addr  s_rd_addr [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_len   s_rd_data [fmsl_pkg::NUM_TREES];
    logic             s_wr_en   [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_addr  s_wr_addr [fmsl_pkg::NUM_TREES];
    fmsl_pkg::t_len   s_wr_data [fmsl_pkg::NUM_TREES];

    logic             s_q_act   [fmsl_pkg::NUM_TREES];
    logic             s_u_act   [fmsl_pkg::NUM_TREES];
    logic             s_q_busy;
    logic             s_u_busy;
    logic             s_accept;
    logic             s_load;
    fmsl_pkg::t_addr  s_h;

    // Decode walk activity
    always_comb begin
        for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) begin
            s_q_act[t] = (r_qpos[t] != '0);
            s_u_act[t] = (r_upos[t] <= fmsl_pkg::TREE_POS);
        end
    end

    assign s_q_busy = s_q_act[fmsl_pkg::TREE_NI] || s_q_act[fmsl_pkg::TREE_IN];
    assign s_u_busy = s_u_act[fmsl_pkg::TREE_NI] || s_u_act[fmsl_pkg::TREE_IN];
    assign s_accept = i_in.valid && i_in.ready;
    assign s_h      = fmsl_pkg::t_addr'(i_in.height);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fmsl_pkg::S_CLEAR:  if (r_clr_cnt == '1) n_state = fmsl_pkg::S_IDLE;
            fmsl_pkg::S_IDLE:   if (s_accept) n_state = fmsl_pkg::S_QUERY;
            fmsl_pkg::S_QUERY:  if (!s_q_busy) n_state = fmsl_pkg::S_UPINIT;
            fmsl_pkg::S_UPINIT: n_state = fmsl_pkg::S_UPDATE;
            fmsl_pkg::S_UPDATE: if (!s_u_busy) n_state = fmsl_pkg::S_DONE;
            fmsl_pkg::S_DONE: begin
                if (s_load) n_state = r_last ? fmsl_pkg::S_CLEAR : fmsl_pkg::S_IDLE;
            end
            default:            n_state = fmsl_pkg::S_CLEAR;
        endcase
    end

    // Drive handshakes and memory ports
    always_comb begin
        i_in.ready = 1'b0;
        s_load     = 1'b0;
        for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) begin
            s_rd_en[t]   = 1'b0;
            s_rd_addr[t] = fmsl_pkg::t_addr'(r_qpos[t] - fmsl_pkg::t_pos'(1));
            s_wr_en[t]   = 1'b0;
            s_wr_addr[t] = r_wr_addr[t];
            s_wr_data[t] = r_val[t];
        end
        unique case (r_state)
            fmsl_pkg::S_CLEAR: begin
                for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) begin
                    s_wr_en[t]   = 1'b1;
                    s_wr_addr[t] = r_clr_cnt;
                    s_wr_data[t] = '0;
                end
            end
            fmsl_pkg::S_IDLE: i_in.ready = 1'b1;
            fmsl_pkg::S_QUERY: begin
                for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) begin
                    s_rd_en[t] = s_q_act[t];
                end
            end
            fmsl_pkg::S_UPINIT: ;
            fmsl_pkg::S_UPDATE: begin
                for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) begin
                    s_rd_en[t]   = s_u_act[t];
                    s_rd_addr[t] = fmsl_pkg::t_addr'(r_upos[t] - fmsl_pkg::t_pos'(1));
                    s_wr_en[t]   = r_rd_vld[t] && (s_rd_data[t] < r_val[t]);
                end
            end
            fmsl_pkg::S_DONE: s_load = !r_out_vld || o_out.ready;
            default: ;
        endcase
    end

    // Tree memories with registered read data
    for (genvar g = 0; g < fmsl_pkg::NUM_TREES; g++) begin : g_tree
        fmsl_pkg::t_len r_mem [fmsl_pkg::TREE_SIZE];
        fmsl_pkg::t_len r_rd_q;

        always_ff @(posedge i_clk) begin
            if (s_wr_en[g]) r_mem[s_wr_addr[g]] <= s_wr_data[g];
            if (s_rd_en[g]) r_rd_q <= r_mem[s_rd_addr[g]];
        end

        assign s_rd_data[g] = r_rd_q;
    end

    // Advance state and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fmsl_pkg::S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fmsl_pkg::S_CLEAR) r_clr_cnt <= r_clr_cnt + fmsl_pkg::t_addr'(1);
            else                              r_clr_cnt <= '0;
        end
    end

    // Walk both trees, each through its own compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) r_rd_vld[t] <= 1'b0;
        end else begin
            for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) r_rd_vld[t] <= s_rd_en[t];
        end

        if (s_accept) begin
            r_last                   <= i_in.last_item;
            r_qpos[fmsl_pkg::TREE_NI] <= fmsl_pkg::TREE_POS - fmsl_pkg::t_pos'(s_h);
            r_upos[fmsl_pkg::TREE_NI] <= fmsl_pkg::TREE_POS - fmsl_pkg::t_pos'(s_h);
            r_qpos[fmsl_pkg::TREE_IN] <= fmsl_pkg::t_pos'(s_h);
            r_upos[fmsl_pkg::TREE_IN] <= fmsl_pkg::t_pos'(s_h) + fmsl_pkg::t_pos'(1);
            for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) r_acc[t] <= '0;
        end

        for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) begin
            if (r_state == fmsl_pkg::S_QUERY) begin
                if (s_q_act[t]) r_qpos[t] <= r_qpos[t] - fmsl_pkg::lowbit(r_qpos[t]);
                if (r_rd_vld[t]) r_acc[t] <= fmsl_pkg::max_len(r_acc[t], s_rd_data[t]);
            end
            if (r_state == fmsl_pkg::S_UPINIT) r_val[t] <= fmsl_pkg::bump(r_acc[t]);
            if (r_state == fmsl_pkg::S_UPDATE && s_u_act[t]) begin
                r_upos[t]    <= r_upos[t] + fmsl_pkg::lowbit(r_upos[t]);
                r_wr_addr[t] <= s_rd_addr[t];
            end
        end
    end

    // Track running best lengths; drop them after the last request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_ni <= '0;
            r_best_in <= '0;
        end else if (r_state == fmsl_pkg::S_UPINIT) begin
            r_best_ni <= fmsl_pkg::max_len(r_best_ni,
                                           fmsl_pkg::bump(r_acc[fmsl_pkg::TREE_NI]));
            r_best_in <= fmsl_pkg::max_len(r_best_in,
                                           fmsl_pkg::bump(r_acc[fmsl_pkg::TREE_IN]));
        end else if (s_load && r_last) begin
            r_best_ni <= '0;
            r_best_in <= '0;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (s_load) begin
            r_out_ni    <= fmsl_pkg::to_field(r_best_ni);
            r_out_in    <= fmsl_pkg::to_field(r_best_in);
            r_out_final <= r_last;
        end
    end

    assign o_out.valid                = r_out_vld;
    assign o_out.nonincreasing_length = r_out_ni;
    assign o_out.increasing_length    = r_out_in;
    assign o_out.is_final             = r_out_final;

    `FMSL_ASSERT_IMP(a_rmw_addr_ni, s_wr_en[fmsl_pkg::TREE_NI] && s_rd_en[fmsl_pkg::TREE_NI] && r_state == fmsl_pkg::S_UPDATE, s_rd_addr[fmsl_pkg::TREE_NI] != s_wr_addr[fmsl_pkg::TREE_NI], "update read hits pending write, non-increasing tree")
    `FMSL_ASSERT_IMP(a_rmw_addr_in, s_wr_en[fmsl_pkg::TREE_IN] && s_rd_en[fmsl_pkg::TREE_IN] && r_state == fmsl_pkg::S_UPDATE, s_rd_addr[fmsl_pkg::TREE_IN] != s_wr_addr[fmsl_pkg::TREE_IN], "update read hits pending write, increasing tree")
    `FMSL_ASSERT_NXT(a_best_mono, r_state == fmsl_pkg::S_UPINIT, r_best_ni >= $past(r_best_ni) && r_best_in >= $past(r_best_in), "running best length decreased")
    `FMSL_ASSERT_IMP(a_load_free, s_load, !r_out_vld || o_out.ready, "result overwrote an untaken result")
    `FMSL_ASSERT_NXT(a_clear_after_last, s_load && r_last, r_state == fmsl_pkg::S_CLEAR && r_clr_cnt == '0 && r_best_ni == '0 && r_best_in == '0, "trees not cleared after last request")

endmodule

FILE: sim/fenwick_max_subsequence_lengths_unit_tb.sv
`timescale 1ns / 1ps

module fenwick_max_subsequence_lengths_unit_tb;

    localparam int          HF_BITS      = fmsl_pkg::HEIGHT_FIELD_BITS;
    localparam int          LF_BITS      = fmsl_pkg::LEN_FIELD_BITS;
    localparam int unsigned TREE_ENTRIES = 1 << fmsl_pkg::HEIGHT_BITS;
    localparam int          DRAIN_CYCLES = 2 * fmsl_pkg::HEIGHT_BITS + 6 + 16;
    localparam int          CYCLE_LIMIT  = 10_000_000;
    localparam int          PHASE_ITEMS  = 300;

    typedef struct packed {
        logic [LF_BITS-1:0] nonincreasing_length;
        logic [LF_BITS-1:0] increasing_length;
        logic               is_final;
    } t_lengths;

    typedef struct packed {
        logic [HF_BITS-1:0] height;
        logic               last_item;
        logic               typed;
        t_lengths           lengths;
    } t_height_row;

    typedef enum int {
        SEG_RISE,
        SEG_FALL,
        SEG_NARROW,
        SEG_FLAT,
        SEG_NOISE
    } t_seg_kind;

    logic i_clk;
    logic i_rst_n;

    fmsl_in_if  in_if ();
    fmsl_out_if out_if ();

    fenwick_max_subsequence_lengths_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state: both prefix-max trees and the running best lengths
    int unsigned len_tree [fmsl_pkg::NUM_TREES][TREE_ENTRIES + 1];
    int unsigned best_nonincr;
    int unsigned best_incr;
    int unsigned len_cap;

    t_lengths    lengths_q [$];
    t_height_row height_rows [$];

    int src_idle_pct;
    int snk_idle_pct;
    int fail_count;
    int requests_sent;
    int results_seen;
    int sequences_closed;
    int items_since_clear;
    int clear_after;
    int cycle_count;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void clear_trees();
        for (int t = 0; t < fmsl_pkg::NUM_TREES; t++) begin
            for (int unsigned p = 0; p <= TREE_ENTRIES; p++) begin
                len_tree[t][p] = 0;
            end
        end
        best_nonincr = 0;
        best_incr    = 0;
    endfunction

    function automatic int unsigned tree_prefix_max(input int lane, input int unsigned pos);
        int unsigned acc;
        acc = 0;
        while (pos > 0) begin
            if (len_tree[lane][pos] > acc) acc = len_tree[lane][pos];
            pos -= pos & (0 - pos);
        end
        return acc;
    endfunction

    function automatic void tree_raise(input int lane, input int unsigned pos,
                                       input int unsigned val);
        while (pos >= 1 && pos <= TREE_ENTRIES) begin
            if (len_tree[lane][pos] < val) len_tree[lane][pos] = val;
            pos += pos & (0 - pos);
        end
    endfunction

    function automatic int unsigned extend_len(input int unsigned q);
        return (q >= len_cap) ? len_cap : q + 1;
    endfunction

    function automatic logic [LF_BITS-1:0] clamp_field(input int unsigned v);
        return (v > 32'h0000_FFFF) ? '1 : LF_BITS'(v);
    endfunction

    // Advance the predictor by one height and return the lengths it reports
    function automatic t_lengths predict_lengths(input logic [HF_BITS-1:0] height,
                                                 input logic last_flag);
        int unsigned h, rev_pos, dir_pos, ln, li;
        t_lengths    r;
        h       = 32'(height) & (TREE_ENTRIES - 1);
        rev_pos = TREE_ENTRIES - h;
        dir_pos = h + 1;

        // non-increasing: earlier heights at or above this one
        ln = extend_len(tree_prefix_max(fmsl_pkg::TREE_NI, rev_pos));
        tree_raise(fmsl_pkg::TREE_NI, rev_pos, ln);
        if (ln > best_nonincr) best_nonincr = ln;

        // strictly increasing: earlier heights below this one
        li = extend_len(tree_prefix_max(fmsl_pkg::TREE_IN, h));
        tree_raise(fmsl_pkg::TREE_IN, dir_pos, li);
        if (li > best_incr) best_incr = li;

        r.nonincreasing_length = clamp_field(best_nonincr);
        r.increasing_length    = clamp_field(best_incr);
        r.is_final             = last_flag;
        if (last_flag) clear_trees();
        return r;
    endfunction

    function automatic void add_row(input logic [HF_BITS-1:0] height, input logic last_flag,
                                    input logic typed, input int unsigned ni,
                                    input int unsigned inc);
        t_height_row row;
        row.height                       = height;
        row.last_item                    = last_flag;
        row.typed                        = typed;
        row.lengths.nonincreasing_length = LF_BITS'(ni);
        row.lengths.increasing_length    = LF_BITS'(inc);
        row.lengths.is_final             = last_flag;
        height_rows.push_back(row);
    endfunction

    // Offer one request, hold it until taken, and record what it must produce
    task automatic send_request(input logic [HF_BITS-1:0] height, input logic last_flag,
                                input logic typed, input t_lengths typed_lengths);
        t_lengths predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.height    <= height;
        in_if.last_item <= last_flag;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted = predict_lengths(height, last_flag);
        lengths_q.push_back(typed ? typed_lengths : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Random heights in segments: rising, falling, narrow band, flat, noise
    task automatic run_random_phase(input int n_items);
        t_seg_kind          kind;
        int                 seg_left;
        logic [HF_BITS-1:0] h;
        logic [HF_BITS-1:0] base;
        logic               last_flag;
        t_lengths           unused;
        seg_left = 0;
        kind     = SEG_NOISE;
        base     = '0;
        h        = '0;
        unused   = '0;
        for (int k = 0; k < n_items; k++) begin
            if (seg_left == 0) begin
                kind     = t_seg_kind'($urandom_range(4));
                seg_left = $urandom_range(40, 3);
                base     = HF_BITS'($urandom);
                h        = base;
            end
            case (kind)
                SEG_RISE:   h = h + HF_BITS'($urandom_range(300, 1));
                SEG_FALL:   h = h - HF_BITS'($urandom_range(300, 0));
                SEG_NARROW: h = base + HF_BITS'($urandom_range(7));
                SEG_FLAT:   h = base;
                default:    h = HF_BITS'($urandom);
            endcase
            seg_left--;
            items_since_clear++;
            last_flag = (items_since_clear >= clear_after);
            if (last_flag) begin
                items_since_clear = 0;
                clear_after       = $urandom_range(240, 60);
                sequences_closed++;
            end
            send_request(h, last_flag, 1'b0, unused);
        end
    endtask

    task automatic wait_drained();
        while (lengths_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: stall at random
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result with the oldest pending expectation
    always @(posedge i_clk) begin : result_check
        t_lengths want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (lengths_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ni=%0d inc=%0d fin=%0b",
                         $time, out_if.nonincreasing_length, out_if.increasing_length,
                         out_if.is_final);
                fail_count++;
            end else begin
                want = lengths_q.pop_front();
                check_field("nonincreasing_length", want.nonincreasing_length,
                            out_if.nonincreasing_length);
                check_field("increasing_length", want.increasing_length,
                            out_if.increasing_length);
                check_field("is_final", want.is_final, out_if.is_final);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, lengths_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.height     = '0;
        in_if.last_item  = 1'b0;
        out_if.ready     = 1'b0;
        src_idle_pct     = 0;
        snk_idle_pct     = 0;
        fail_count       = 0;
        requests_sent    = 0;
        results_seen     = 0;
        sequences_closed = 0;
        cycle_count      = 0;
        items_since_clear = 0;
        clear_after      = $urandom_range(240, 60);
        len_cap          = 32'((64'd1 << fmsl_pkg::LENGTH_BITS) - 64'd1);
        clear_trees();

        // Hold reset, then release at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: zero and top heights, repeats, runs, clears
        add_row(16'd0,     1'b0, 1'b1, 1, 1);
        add_row(16'hFFFF,  1'b0, 1'b1, 1, 2);
        add_row(16'hFFFF,  1'b0, 1'b1, 2, 2);
        add_row(16'd0,     1'b0, 1'b1, 3, 2);
        add_row(16'd0,     1'b1, 1'b1, 4, 2);
        add_row(16'd100,   1'b0, 1'b1, 1, 1);
        add_row(16'd200,   1'b0, 1'b0, 0, 0);
        add_row(16'd300,   1'b0, 1'b0, 0, 0);
        add_row(16'd400,   1'b0, 1'b0, 0, 0);
        add_row(16'd500,   1'b0, 1'b0, 0, 0);
        add_row(16'd450,   1'b0, 1'b0, 0, 0);
        add_row(16'd450,   1'b0, 1'b0, 0, 0);
        add_row(16'd440,   1'b0, 1'b0, 0, 0);
        add_row(16'd7,     1'b0, 1'b0, 0, 0);
        add_row(16'd7,     1'b0, 1'b0, 0, 0);
        add_row(16'd7,     1'b0, 1'b0, 0, 0);
        add_row(16'd1,     1'b0, 1'b0, 0, 0);
        add_row(16'h8000,  1'b0, 1'b0, 0, 0);
        add_row(16'h7FFF,  1'b0, 1'b0, 0, 0);
        add_row(16'hFFFE,  1'b0, 1'b0, 0, 0);
        add_row(16'hFFFF,  1'b1, 1'b0, 0, 0);
        add_row(16'hAAAA,  1'b0, 1'b1, 1, 1);
        add_row(16'h5555,  1'b0, 1'b1, 2, 1);
        foreach (height_rows[i]) begin
            send_request(height_rows[i].height, height_rows[i].last_item,
                         height_rows[i].typed, height_rows[i].lengths);
        end
        sequences_closed += 2;
        in_if.valid <= 1'b0;
        wait_drained();

        // Random phases: sender mostly busy, then receiver mostly busy, then no idling
        src_idle_pct = 10;
        snk_idle_pct = 57;
        run_random_phase(PHASE_ITEMS);
        in_if.valid <= 1'b0;
        wait_drained();

        src_idle_pct = 57;
        snk_idle_pct = 10;
        run_random_phase(PHASE_ITEMS);
        in_if.valid <= 1'b0;
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);
        in_if.valid <= 1'b0;
        wait_drained();

        // Let any stray result show up before judging
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d height requests and %0d results over %0d closed sequences,",
                 requests_sent, results_seen, sequences_closed);
        $display("with sender and receiver stalls in turn and a stretch at full rate.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
